/* hw/rtl/wce_pkg.sv */
// Shared constants, types and codes of the weighted cut expansion unit.
package wce_pkg;

    // Graph size and fixed-point format of the quotient.
    localparam int unsigned VERTICES      = 65536;
    localparam int unsigned FRACTION_BITS = 16;
    localparam int unsigned ADDR_W        = $clog2(VERTICES);

    // Index compare width covers the largest supported vertex count.
    localparam int unsigned IDX_CMP_W     = 25;

    // Field widths.
    localparam int unsigned FUNC_W        = 2;
    localparam int unsigned VTX_W         = 16;
    localparam int unsigned WEIGHT_W      = 32;
    localparam int unsigned NUM_W         = 32;
    localparam int unsigned DEN_W         = 31;
    localparam int unsigned SUM_W         = 63;
    localparam int unsigned QUOT_OUT_W    = 64;

    // Divider: dividend is the total shifted up by the fraction bits.
    localparam int unsigned DVD_W         = SUM_W + FRACTION_BITS;
    localparam int unsigned QUOT_W        = DVD_W + 2;
    localparam int unsigned CNT_W         = $clog2(DVD_W + 1);

    // Stream and configuration port widths.
    localparam int unsigned S_TDATA_W     = 104;
    localparam int unsigned M_TDATA_W     = 192;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = 32;

    // Membership memory word: cut bit above reciprocal bit.
    localparam int unsigned MEM_W         = 2;
    localparam int unsigned MEM_CUT       = 1;
    localparam int unsigned MEM_REC       = 0;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_NUMERATOR   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DENOMINATOR = 1'b1;

    // Request kinds carried in s_tuser.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_VERTEX = 2'd0,
        FUNC_EDGE   = 2'd1,
        FUNC_FINISH = 2'd2
    } func_t;

    // Saturating add of two values that are at most 2^63-1.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

/* hw/rtl/wce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wce_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/weighted_cut_expansion_unit.sv */
// Weighted cut expansion unit: membership store, shared multiply-accumulate and divider.
// A vertex request passes a multiply and three add states before the next acceptance;
// an edge request two reads, a multiply and, to add to the total, an add state; an unused
// kind returns to idle at once. s_tready is low meanwhile. A finish runs the divider, one
// step per quotient bit, unless the smaller volume is zero, then registers its result when
// the output is free. Synchronous active-low reset; a pass then clears membership memory.
module weighted_cut_expansion_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: vertex[15:0], in_cut[16], in_reciprocal[17], vertex_weight[49:18],
    //          neighbor[65:50], edge_weight[97:66], zero fill[103:98]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wce_pkg::S_TDATA_W-1:0]       s_tdata,
    // s_tuser: func[1:0]
    input  logic [wce_pkg::FUNC_W-1:0]          s_tuser,
    // m_tdata: cut_edge_total[62:0], smaller_volume[125:63], expansion_q16[189:126],
    //          zero fill[191:190]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wce_pkg::M_TDATA_W-1:0]       m_tdata,
    // m_tuser: divide_by_zero[0]
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wce_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wce_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import wce_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_V_MUL,
        ST_V_ADD_CUT,
        ST_V_ADD_REC,
        ST_V_ADD_PEN,
        ST_E_RD_COL,
        ST_E_RD_ROW,
        ST_E_MUL,
        ST_E_ADD,
        ST_F_DIV,
        ST_F_OUT
    } state_t;

    // Registers.
    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [VTX_W-1:0]        vtx_reg, vtx_next;
    logic [VTX_W-1:0]        nb_reg, nb_next;
    logic                    cut_bit_reg, cut_bit_next;
    logic                    rec_bit_reg, rec_bit_next;
    logic [WEIGHT_W-1:0]     weight_reg, weight_next;
    logic [MEM_W-1:0]        col_bits_reg, col_bits_next;
    logic [SUM_W-1:0]        prod_reg, prod_next;
    logic [SUM_W-1:0]        cut_vol_reg, cut_vol_next;
    logic [SUM_W-1:0]        rec_vol_reg, rec_vol_next;
    logic [SUM_W-1:0]        cross_reg, cross_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [SUM_W-1:0]        total_reg, total_next;
    logic [SUM_W-1:0]        divisor_reg, divisor_next;
    logic                    dz_reg, dz_next;
    logic [SUM_W-1:0]        rem_reg, rem_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [QUOT_W-1:0]       quot_reg, quot_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    // Input unpacking.
    logic [VTX_W-1:0]        in_vertex;
    logic                    in_cut;
    logic                    in_reciprocal;
    logic [WEIGHT_W-1:0]     in_vertex_weight;
    logic [VTX_W-1:0]        in_neighbor;
    logic [WEIGHT_W-1:0]     in_edge_weight;
    func_t                   in_func;
    logic                    s_fire;
    logic                    vtx_in_range;
    logic                    nb_in_range;

    assign in_vertex        = s_tdata[15:0];
    assign in_cut           = s_tdata[16];
    assign in_reciprocal    = s_tdata[17];
    assign in_vertex_weight = s_tdata[49:18];
    assign in_neighbor      = s_tdata[65:50];
    assign in_edge_weight   = s_tdata[97:66];
    assign in_func          = func_t'(s_tuser);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign vtx_in_range = (IDX_CMP_W'(in_vertex) < IDX_CMP_W'(VERTICES));
    assign nb_in_range  = (IDX_CMP_W'(in_neighbor) < IDX_CMP_W'(VERTICES));

    // Membership memory port control.
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [MEM_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [MEM_W-1:0]        ram_rdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if (s_fire && in_func == FUNC_VERTEX && vtx_in_range) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(in_vertex);
            ram_wdata[MEM_CUT] = in_cut;
            ram_wdata[MEM_REC] = in_reciprocal;
        end
        ram_raddr = (state_reg == ST_E_RD_COL) ? ADDR_W'(vtx_reg) : ADDR_W'(nb_reg);
    end

    wce_ram #(
        .WIDTH (MEM_W),
        .DEPTH (VERTICES)
    ) u_membership (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared multiplier: weight times effective denominator or numerator.
    logic                    num_neg;
    logic [DEN_W-1:0]        eff_den;
    logic [DEN_W-1:0]        mul_b;
    logic [SUM_W-1:0]        mul_out;

    assign num_neg = num_reg[NUM_W-1];
    assign eff_den = num_neg ? DEN_W'(1) : den_reg;
    assign mul_b   = (state_reg == ST_V_ADD_REC) ? num_reg[DEN_W-1:0] : eff_den;
    assign mul_out = SUM_W'(weight_reg * mul_b);

    // Shared saturating accumulator.
    logic [SUM_W-1:0]        add_a;
    logic [SUM_W-1:0]        add_out;

    always_comb begin
        unique case (state_reg)
            ST_V_ADD_CUT: add_a = cut_vol_reg;
            ST_V_ADD_REC: add_a = rec_vol_reg;
            default:      add_a = cross_reg;
        endcase
    end
    assign add_out = sat_add(add_a, prod_reg);

    // Restoring divider step: one quotient bit per cycle.
    logic [SUM_W:0]          rem_sh;
    logic [SUM_W:0]          rem_diff;
    logic                    div_ge;

    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, divisor_reg};
    assign div_ge   = (rem_sh >= {1'b0, divisor_reg});

    // Smaller volume and output readiness.
    logic [SUM_W-1:0]        min_vol;
    logic                    out_free;
    logic [QUOT_OUT_W-1:0]   quot_sat;

    assign min_vol  = (cut_vol_reg < rec_vol_reg) ? cut_vol_reg : rec_vol_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign quot_sat = (|quot_reg[QUOT_W-1:QUOT_OUT_W]) ? {QUOT_OUT_W{1'b1}}
                                                       : quot_reg[QUOT_OUT_W-1:0];

    // Sequencer next-state and datapath logic.
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        vtx_next      = vtx_reg;
        nb_next       = nb_reg;
        cut_bit_next  = cut_bit_reg;
        rec_bit_next  = rec_bit_reg;
        weight_next   = weight_reg;
        col_bits_next = col_bits_reg;
        prod_next     = prod_reg;
        cut_vol_next  = cut_vol_reg;
        rec_vol_next  = rec_vol_reg;
        cross_next    = cross_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        total_next    = total_reg;
        divisor_next  = divisor_reg;
        dz_next       = dz_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        quot_next     = quot_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // Result register drains on its handshake.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Configuration writes.
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_NUMERATOR:   num_next = cfg_data;
                REG_DENOMINATOR: den_next = cfg_data[DEN_W-1:0];
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(VERTICES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    vtx_next     = in_vertex;
                    nb_next      = in_neighbor;
                    cut_bit_next = in_cut;
                    rec_bit_next = in_reciprocal;
                    unique case (in_func)
                        FUNC_VERTEX: begin
                            weight_next = in_vertex_weight;
                            if (vtx_in_range) begin
                                state_next = ST_V_MUL;
                            end
                        end
                        FUNC_EDGE: begin
                            weight_next = in_edge_weight;
                            if (vtx_in_range && nb_in_range) begin
                                state_next = ST_E_RD_COL;
                            end
                        end
                        FUNC_FINISH: begin
                            total_next   = cross_reg;
                            divisor_next = min_vol;
                            dz_next      = (min_vol == '0);
                            rem_next     = '0;
                            dvd_next     = DVD_W'(cross_reg) << FRACTION_BITS;
                            quot_next    = '0;
                            cnt_next     = CNT_W'(DVD_W);
                            cross_next   = '0;
                            cut_vol_next = '0;
                            rec_vol_next = '0;
                            state_next   = (min_vol == '0) ? ST_F_OUT : ST_F_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_V_MUL: begin
                prod_next  = mul_out;
                state_next = ST_V_ADD_CUT;
            end
            ST_V_ADD_CUT: begin
                if (cut_bit_reg) begin
                    cut_vol_next = add_out;
                end
                state_next = ST_V_ADD_REC;
            end
            ST_V_ADD_REC: begin
                if (rec_bit_reg) begin
                    rec_vol_next = add_out;
                end
                // Multiplier now forms the penalty product.
                prod_next  = mul_out;
                state_next = ST_V_ADD_PEN;
            end
            ST_V_ADD_PEN: begin
                if (cut_bit_reg && rec_bit_reg && !num_neg && num_reg != '0) begin
                    cross_next = add_out;
                end
                state_next = ST_IDLE;
            end
            ST_E_RD_COL: begin
                state_next = ST_E_RD_ROW;
            end
            ST_E_RD_ROW: begin
                col_bits_next = ram_rdata;
                state_next    = ST_E_MUL;
            end
            ST_E_MUL: begin
                prod_next = mul_out;
                if (col_bits_reg[MEM_CUT] && !col_bits_reg[MEM_REC] && !ram_rdata[MEM_CUT]) begin
                    state_next = ST_E_ADD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_E_ADD: begin
                cross_next = add_out;
                state_next = ST_IDLE;
            end
            ST_F_DIV: begin
                rem_next  = div_ge ? rem_diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
                dvd_next  = dvd_reg << 1;
                quot_next = {quot_reg[QUOT_W-2:0], div_ge};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_F_OUT;
                end
            end
            ST_F_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[62:0]    = total_reg;
                    m_tdata_next[125:63]  = divisor_reg;
                    m_tdata_next[189:126] = dz_reg ? '0 : quot_sat;
                    m_tuser_next  = dz_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cut_vol_reg  <= '0;
            rec_vol_reg  <= '0;
            cross_reg    <= '0;
            num_reg      <= '0;
            den_reg      <= DEN_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cut_vol_reg  <= cut_vol_next;
            rec_vol_reg  <= rec_vol_next;
            cross_reg    <= cross_next;
            num_reg      <= num_next;
            den_reg      <= den_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        vtx_reg      <= vtx_next;
        nb_reg       <= nb_next;
        cut_bit_reg  <= cut_bit_next;
        rec_bit_reg  <= rec_bit_next;
        weight_reg   <= weight_next;
        col_bits_reg <= col_bits_next;
        prod_reg     <= prod_next;
        total_reg    <= total_next;
        divisor_reg  <= divisor_next;
        dz_reg       <= dz_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* hw/rtl/wce_checker.sv */
// Port-level checks of the weighted cut expansion unit, bound to its top level.
module wce_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [wce_pkg::M_TDATA_W-1:0]       m_tdata,
    input logic                                m_tuser
);

    import wce_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // The zero-volume flag matches the reported volume, and the quotient is zero with it.
    a_dz_volume: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata[125:63] == '0)))
        else $error("divide-by-zero flag disagrees with smaller volume");

    a_dz_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[189:126] == '0))
        else $error("nonzero quotient with divide-by-zero flag");

    // After reset the memory clearing pass holds off requests and no result is shown.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("block active right after reset");

endmodule

bind weighted_cut_expansion_unit wce_checker u_wce_checker (.*);
